[rtl/bcde_pkg.sv]
// shared constants, types and helpers for the binary cross dilate/erode unit
package bcde_pkg;

    // default largest image side supported by the row memories
    localparam int DEFAULT_MAX_SIDE = 16;

    // width and reset value of the image size register
    localparam int          SIZE_W     = 5;
    localparam logic [4:0]  SIZE_RESET = 5'd16;

    // depth of the queue between front and back
    localparam int QUEUE_DEPTH = 2;

    // three row memories rotate through current, middle and upper roles
    localparam int NUM_BANKS = 3;

    typedef logic [1:0] t_bank;

    // per item classification made by the front
    typedef struct packed {
        logic pixel;
        logic row_ge1;
        logic row_ge2;
        logic row_end;
        logic last;
    } t_in_flags;

    // one result job issued by the back sequencer
    typedef struct packed {
        t_bank cbank;
        t_bank ubank;
        logic  up_en;
        logic  down;
        logic  left_en;
        logic  right_en;
        logic  run_end;
        logic  image_end;
    } t_job;

    // bank that follows b in the rotation
    function automatic t_bank bank_next(input t_bank b);
        t_bank nb;
        case (b)
            2'd0:    nb = 2'd1;
            2'd1:    nb = 2'd2;
            default: nb = 2'd0;
        endcase
        return nb;
    endfunction

    // bank that precedes b in the rotation
    function automatic t_bank bank_prev(input t_bank b);
        t_bank pb;
        case (b)
            2'd0:    pb = 2'd2;
            2'd1:    pb = 2'd0;
            default: pb = 2'd1;
        endcase
        return pb;
    endfunction

endpackage

[rtl/bcde_front.sv]
// front end: size register, raster position counters and item classification
module bcde_front #(
    parameter int MAX_SIDE = bcde_pkg::DEFAULT_MAX_SIDE,
    parameter int CW       = $clog2(MAX_SIDE)
) (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_cfg_valid,
    input  logic [bcde_pkg::SIZE_W-1:0] i_cfg_data,
    output logic                       o_cfg_ready,
    input  logic                       i_valid,
    input  logic                       i_pixel_in,
    output logic                       o_stall,
    input  logic                       i_full,
    output logic                       o_push,
    output logic [CW-1:0]              o_push_col,
    output bcde_pkg::t_in_flags        o_push_flags,
    output logic [CW-1:0]              o_last_col
);

    logic [bcde_pkg::SIZE_W-1:0] r_size;
    logic [CW-1:0]               r_col;
    logic [CW-1:0]               r_row;
    logic [CW-1:0]               n_col;
    logic [CW-1:0]               n_row;
    logic [CW-1:0]               last_col;
    logic                        row_end;
    logic                        img_last;
    logic                        push;

    // last column index of the effective side, clamped to 1..MAX_SIDE
    always_comb begin
        if (r_size == '0) begin
            last_col = '0;
        end else if (32'(r_size) > 32'(MAX_SIDE)) begin
            last_col = CW'(MAX_SIDE - 1);
        end else begin
            last_col = CW'(r_size - 1'b1);
        end
    end

    assign row_end  = (r_col == last_col);
    assign img_last = row_end && (r_row == last_col);
    assign push     = i_valid && !i_full;

    // next raster position
    always_comb begin
        n_col = r_col;
        n_row = r_row;
        if (push) begin
            if (img_last) begin
                n_col = '0;
                n_row = '0;
            end else if (row_end) begin
                n_col = '0;
                n_row = r_row + 1'b1;
            end else begin
                n_col = r_col + 1'b1;
            end
        end
    end

    // size register and counters; a size write restarts the image
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_size <= bcde_pkg::SIZE_RESET;
            r_col  <= '0;
            r_row  <= '0;
        end else if (i_cfg_valid) begin
            r_size <= i_cfg_data;
            r_col  <= '0;
            r_row  <= '0;
        end else begin
            r_col <= n_col;
            r_row <= n_row;
        end
    end

    // classification of the accepted item
    always_comb begin
        o_push_flags.pixel   = i_pixel_in;
        o_push_flags.row_ge1 = (r_row != '0);
        o_push_flags.row_ge2 = (32'(r_row) >= 32'd2);
        o_push_flags.row_end = row_end;
        o_push_flags.last    = img_last;
    end

    assign o_push      = push;
    assign o_push_col  = r_col;
    assign o_last_col  = last_col;
    assign o_stall     = i_full;
    assign o_cfg_ready = 1'b1;

endmodule

[rtl/bcde_queue.sv]
// short fifo that decouples the front from the back sequencer
module bcde_queue #(
    parameter int DATA_W = 8,
    parameter int DEPTH  = bcde_pkg::QUEUE_DEPTH
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_push,
    input  logic [DATA_W-1:0] i_data,
    output logic              o_full,
    input  logic              i_pop,
    output logic              o_valid,
    output logic [DATA_W-1:0] o_data
);

    localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int NW = $clog2(DEPTH + 1);

    logic [DATA_W-1:0] r_slot [DEPTH];
    logic [PW-1:0]     r_wr_ptr;
    logic [PW-1:0]     r_rd_ptr;
    logic [NW-1:0]     r_count;
    logic              do_push;
    logic              do_pop;

    assign o_full  = (r_count == NW'(DEPTH));
    assign o_valid = (r_count != '0);
    assign o_data  = r_slot[r_rd_ptr];
    assign do_push = i_push && !o_full;
    assign do_pop  = i_pop && o_valid;

    // storage
    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_slot[r_wr_ptr] <= i_data;
        end
    end

    // pointers and fill count
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (do_push) begin
                r_wr_ptr <= (r_wr_ptr == PW'(DEPTH - 1)) ? '0 : r_wr_ptr + 1'b1;
            end
            if (do_pop) begin
                r_rd_ptr <= (r_rd_ptr == PW'(DEPTH - 1)) ? '0 : r_rd_ptr + 1'b1;
            end
            case ({do_push, do_pop})
                2'b10:   r_count <= r_count + 1'b1;
                2'b01:   r_count <= r_count - 1'b1;
                default: r_count <= r_count;
            endcase
        end
    end

endmodule

[rtl/bcde_back.sv]
// back end: rotating row memories, result sequencer and output register
module bcde_back #(
    parameter int MAX_SIDE = bcde_pkg::DEFAULT_MAX_SIDE,
    parameter int CW       = $clog2(MAX_SIDE)
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic [CW-1:0]       i_last_col,
    input  logic                i_q_valid,
    input  bcde_pkg::t_in_flags i_q_flags,
    input  logic [CW-1:0]       i_q_col,
    output logic                o_q_pop,
    input  logic                i_stall,
    output logic                o_valid,
    output logic                o_dilated_pixel,
    output logic                o_eroded_pixel,
    output logic                o_run_end,
    output logic                o_image_end
);

    localparam int NB = bcde_pkg::NUM_BANKS;

    // row memories, one bit per column
    logic r_mem [NB][MAX_SIDE];

    // sequencer state
    bcde_pkg::t_bank r_bank;
    bcde_pkg::t_bank n_bank;
    logic            r_flush;
    logic            n_flush;
    logic [CW-1:0]   r_fidx;
    logic [CW-1:0]   n_fidx;
    bcde_pkg::t_bank r_fbank;
    bcde_pkg::t_bank n_fbank;
    logic            r_fup_en;
    logic            n_fup_en;

    // issue side
    logic            en;
    logic            pop;
    logic            iss_valid;
    bcde_pkg::t_job  iss_job;
    logic [CW-1:0]   iss_addr;
    logic [CW-1:0]   iss_addr_nxt;

    // read data stage
    logic            r_b_valid;
    bcde_pkg::t_job  r_b_job;
    logic [NB-1:0]   r_rd_cur;
    logic [NB-1:0]   r_rd_nxt;
    logic            r_prev_center;

    // output register
    logic            r_o_valid;
    logic            r_o_dil;
    logic            r_o_ero;
    logic            r_o_run_end;
    logic            r_o_image_end;

    logic            w_center;
    logic            w_left;
    logic            w_right;
    logic            w_up;
    logic            w_down;

    function automatic logic pick(input logic [NB-1:0] v, input bcde_pkg::t_bank b);
        logic bit_sel;
        case (b)
            2'd0:    bit_sel = v[0];
            2'd1:    bit_sel = v[1];
            2'd2:    bit_sel = v[2];
            default: bit_sel = 1'b0;
        endcase
        return bit_sel;
    endfunction

    // whole pipeline moves unless a result waits on a stalled receiver
    assign en      = !r_o_valid || !i_stall;
    assign o_q_pop = pop && en;

    // job sequencer: one queue entry or one flush column per cycle while the pipeline moves
    always_comb begin
        pop       = 1'b0;
        iss_valid = 1'b0;
        iss_job   = '0;
        iss_addr  = i_q_col;
        n_bank    = r_bank;
        n_flush   = r_flush;
        n_fidx    = r_fidx;
        n_fbank   = r_fbank;
        n_fup_en  = r_fup_en;
        if (r_flush) begin
            // last row of the image, one column per cycle while the pipeline moves
            iss_valid         = 1'b1;
            iss_addr          = r_fidx;
            iss_job.cbank     = r_fbank;
            iss_job.ubank     = bcde_pkg::bank_prev(r_fbank);
            iss_job.up_en     = r_fup_en;
            iss_job.down      = 1'b0;
            iss_job.left_en   = (r_fidx != '0);
            iss_job.right_en  = (r_fidx != i_last_col);
            iss_job.run_end   = (r_fidx == i_last_col);
            iss_job.image_end = (r_fidx == i_last_col);
            if (r_fidx == i_last_col) begin
                n_flush = 1'b0;
            end else begin
                n_fidx = r_fidx + 1'b1;
            end
        end else if (i_q_valid) begin
            pop = 1'b1;
            // result for the pixel one row above
            if (i_q_flags.row_ge1) begin
                iss_valid         = 1'b1;
                iss_job.cbank     = bcde_pkg::bank_prev(r_bank);
                iss_job.ubank     = bcde_pkg::bank_prev(bcde_pkg::bank_prev(r_bank));
                iss_job.up_en     = i_q_flags.row_ge2;
                iss_job.down      = i_q_flags.pixel;
                iss_job.left_en   = (i_q_col != '0);
                iss_job.right_en  = (i_q_col != i_last_col);
                iss_job.run_end   = !i_q_flags.last;
                iss_job.image_end = 1'b0;
            end
            if (i_q_flags.last) begin
                n_flush  = 1'b1;
                n_fidx   = '0;
                n_fbank  = r_bank;
                n_fup_en = i_q_flags.row_ge1;
            end
            if (i_q_flags.row_end) begin
                n_bank = bcde_pkg::bank_next(r_bank);
            end
        end
    end

    assign iss_addr_nxt = iss_addr + 1'b1;

    // row memories: pixel write and registered reads at column and column + 1
    always_ff @(posedge i_clk) begin
        if (en && pop) begin
            r_mem[r_bank][i_q_col] <= i_q_flags.pixel;
        end
        if (en) begin
            for (int k = 0; k < NB; k++) begin
                r_rd_cur[k] <= r_mem[k][iss_addr];
                r_rd_nxt[k] <= r_mem[k][iss_addr_nxt];
            end
        end
    end

    // cross window from the read data
    assign w_center = pick(r_rd_cur, r_b_job.cbank);
    assign w_right  = r_b_job.right_en && pick(r_rd_nxt, r_b_job.cbank);
    assign w_up     = r_b_job.up_en && pick(r_rd_cur, r_b_job.ubank);
    assign w_left   = r_b_job.left_en && r_prev_center;
    assign w_down   = r_b_job.down;

    // control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_bank    <= '0;
            r_flush   <= 1'b0;
            r_fidx    <= '0;
            r_fbank   <= '0;
            r_fup_en  <= 1'b0;
            r_b_valid <= 1'b0;
            r_o_valid <= 1'b0;
        end else if (en) begin
            r_bank    <= n_bank;
            r_flush   <= n_flush;
            r_fidx    <= n_fidx;
            r_fbank   <= n_fbank;
            r_fup_en  <= n_fup_en;
            r_b_valid <= iss_valid;
            r_o_valid <= r_b_valid;
        end
    end

    // payload registers
    always_ff @(posedge i_clk) begin
        if (en) begin
            r_b_job <= iss_job;
            if (r_b_valid) begin
                r_prev_center <= w_center;
            end
            r_o_dil       <= w_center | w_left | w_right | w_up | w_down;
            r_o_ero       <= w_center & w_left & w_right & w_up & w_down;
            r_o_run_end   <= r_b_job.run_end;
            r_o_image_end <= r_b_job.image_end;
        end
    end

    assign o_valid         = r_o_valid;
    assign o_dilated_pixel = r_o_dil;
    assign o_eroded_pixel  = r_o_ero;
    assign o_run_end       = r_o_run_end;
    assign o_image_end     = r_o_image_end;

    // no queue entry is taken while the last row is being flushed
    a_no_pop_in_flush: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(r_flush && o_q_pop))
        else $error("queue popped during flush");

    // flush stops after the last column
    a_flush_ends: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (en && r_flush && (r_fidx == i_last_col)) |=> !r_flush)
        else $error("flush ran past the last column");

    // the final pixel of an image always closes its run
    a_image_end_run_end: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_o_valid && r_o_image_end) |-> r_o_run_end)
        else $error("image end without run end");

endmodule

[rtl/binary_cross_dilate_erode_unit.sv]
// top level of the binary 3x3 cross dilate/erode unit
//
// Usage:
//   Pixels enter in raster order on i_valid / i_pixel_in, one per cycle,
//   and are taken when o_stall is low. Each item from the second row on
//   gives one result for the pixel above it; the final pixel of the image
//   also gives the whole last row, so it yields up to side + 1 results.
//   Results leave on o_valid with dilated, eroded, run end and image end
//   bits, and are taken when i_stall is low. The image side is written on
//   the cfg channel (o_cfg_ready is always high) while the unit is idle;
//   a write restarts the image.
//   An accepted item passes through the queue; its result is then held in
//   the read data stage and the output register. Throughput: one item per
//   cycle while o_stall is low; the final pixel of an image holds the back
//   end while the flush reads the last row, one column of the row memories
//   per cycle, and the two entry queue then fills and raises o_stall.
//   A stalled receiver freezes the back end; the queue takes up to two more
//   items before o_stall rises. Reset empties queue and pipeline, zeroes
//   the counters and sets the side to 16; no clearing pass is needed.
module binary_cross_dilate_erode_unit #(
    parameter int MAX_SIDE = bcde_pkg::DEFAULT_MAX_SIDE
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_cfg_valid,
    input  logic [bcde_pkg::SIZE_W-1:0] i_cfg_data,
    output logic                        o_cfg_ready,
    input  logic                        i_valid,
    input  logic                        i_pixel_in,
    output logic                        o_stall,
    output logic                        o_valid,
    input  logic                        i_stall,
    output logic                        o_dilated_pixel,
    output logic                        o_eroded_pixel,
    output logic                        o_run_end,
    output logic                        o_image_end
);

    localparam int CW = $clog2(MAX_SIDE);
    localparam int FW = $bits(bcde_pkg::t_in_flags);
    localparam int QW = FW + CW;

    logic                push;
    logic [CW-1:0]       push_col;
    bcde_pkg::t_in_flags push_flags;
    logic [CW-1:0]       last_col;
    logic                q_full;
    logic                q_valid;
    logic [QW-1:0]       q_data;
    logic                q_pop;
    bcde_pkg::t_in_flags q_flags;
    logic [CW-1:0]       q_col;

    // position tracking and classification
    bcde_front #(
        .MAX_SIDE (MAX_SIDE),
        .CW       (CW)
    ) u_front (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cfg_valid  (i_cfg_valid),
        .i_cfg_data   (i_cfg_data),
        .o_cfg_ready  (o_cfg_ready),
        .i_valid      (i_valid),
        .i_pixel_in   (i_pixel_in),
        .o_stall      (o_stall),
        .i_full       (q_full),
        .o_push       (push),
        .o_push_col   (push_col),
        .o_push_flags (push_flags),
        .o_last_col   (last_col)
    );

    // item queue between front and back
    bcde_queue #(
        .DATA_W (QW),
        .DEPTH  (bcde_pkg::QUEUE_DEPTH)
    ) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_data  ({push_flags, push_col}),
        .o_full  (q_full),
        .i_pop   (q_pop),
        .o_valid (q_valid),
        .o_data  (q_data)
    );

    assign q_flags = q_data[QW-1:CW];
    assign q_col   = q_data[CW-1:0];

    // row memories and result generation
    bcde_back #(
        .MAX_SIDE (MAX_SIDE),
        .CW       (CW)
    ) u_back (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_last_col      (last_col),
        .i_q_valid       (q_valid),
        .i_q_flags       (q_flags),
        .i_q_col         (q_col),
        .o_q_pop         (q_pop),
        .i_stall         (i_stall),
        .o_valid         (o_valid),
        .o_dilated_pixel (o_dilated_pixel),
        .o_eroded_pixel  (o_eroded_pixel),
        .o_run_end       (o_run_end),
        .o_image_end     (o_image_end)
    );

endmodule
